FILE: hw/rtl/lcfs_pkg.sv
// ----------------------------------------------------------------------------
// lcfs_pkg
// Shared types and constants of the start/length/checksum/end frame sniffer.
// ----------------------------------------------------------------------------
package lcfs_pkg;

  localparam int TIME_W = 48;

  // one received word
  typedef struct packed {
    logic [1:0]        operation;
    logic [7:0]        data_byte;
    logic [TIME_W-1:0] arrival_time;
  } item_t;

  // one reported byte
  typedef struct packed {
    logic [2:0]        report_kind;
    logic [7:0]        report_byte;
    logic [5:0]        byte_position;
    logic              last_in_report;
    logic [TIME_W-1:0] report_time;
    logic [7:0]        computed_checksum;
  } report_t;

  typedef enum logic [1:0] {
    OP_BYTE     = 2'd0,
    OP_TIMEOUT  = 2'd1,
    OP_OVERFLOW = 2'd2,
    OP_UNUSED   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_OK        = 3'd0,
    KIND_STRAY     = 3'd1,
    KIND_LEN_SMALL = 3'd2,
    KIND_LEN_LARGE = 3'd3,
    KIND_BAD_END   = 3'd4,
    KIND_BAD_SUM   = 3'd5,
    KIND_TIMEOUT   = 3'd6,
    KIND_OVERFLOW  = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    CFG_START_MARKER = 2'd0,
    CFG_END_MARKER   = 2'd1,
    CFG_MAX_LENGTH   = 2'd2,
    CFG_STRAY_LIMIT  = 2'd3
  } cfg_reg_t;

  localparam logic [7:0] START_MARKER_RESET = 8'h68;
  localparam logic [7:0] END_MARKER_RESET   = 8'h43;
  localparam logic [5:0] MAX_LENGTH_RESET   = 6'd62;
  localparam logic [4:0] STRAY_LIMIT_RESET  = 5'd16;
  localparam logic [7:0] MIN_LENGTH         = 8'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SHOW
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic exec;
    logic rd_issue;
    logic step;
    logic finish;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic run_go;
    logic run_last;
  } dp_status_t;

endpackage

FILE: hw/rtl/lcfs_ram.sv
// ----------------------------------------------------------------------------
// lcfs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lcfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/lcfs_ctrl.sv
// ----------------------------------------------------------------------------
// lcfs_ctrl
// Sequencer: takes one word, lets the datapath act on it, then replays the
// resulting run, if there is one, one byte at a time.
// ----------------------------------------------------------------------------
module lcfs_ctrl import lcfs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  output logic       report_valid,
  input  logic       report_ready,
  input  dp_status_t status,
  output ctl_cmd_t   cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = status.run_go ? ST_READ : ST_IDLE;
      end
      ST_READ: begin
        state_next = ST_SHOW;
      end
      ST_SHOW: begin
        if (report_ready) state_next = status.run_last ? ST_IDLE : ST_READ;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready   = (state == ST_IDLE);
    report_valid = (state == ST_SHOW);
    cmd.latch    = (state == ST_IDLE) && item_valid;
    cmd.exec     = (state == ST_EXEC);
    cmd.rd_issue = (state == ST_READ);
    cmd.step     = (state == ST_SHOW) && report_ready && !status.run_last;
    cmd.finish   = (state == ST_SHOW) && report_ready && status.run_last;
  end

endmodule

FILE: hw/rtl/lcfs_dpath.sv
// ----------------------------------------------------------------------------
// lcfs_dpath
// Frame and stray hold stores, configuration registers, checksum and run
// bookkeeping of the frame sniffer.
// ----------------------------------------------------------------------------
module lcfs_dpath import lcfs_pkg::*; #(
  parameter int FRAME_CAPACITY = 64,
  parameter int STRAY_CAPACITY = 16,
  parameter int TIME_BITS      = 48
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  item_t      item,
  input  ctl_cmd_t   cmd,
  output dp_status_t status,
  output report_t    report
);

  localparam int FILL_W = $clog2(FRAME_CAPACITY + 1);
  localparam int FA_W   = $clog2(FRAME_CAPACITY);
  localparam int SF_W   = $clog2(STRAY_CAPACITY + 1);
  localparam int SA_W   = (STRAY_CAPACITY > 1) ? $clog2(STRAY_CAPACITY) : 1;
  localparam int RUN_W  = (FILL_W > SF_W) ? FILL_W : SF_W;
  localparam int TS_W   = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;
  localparam logic [7:0] MAX_LEN_CAP = 8'(FRAME_CAPACITY - 2);
  localparam logic [7:0] STRAY_CAP   = 8'(STRAY_CAPACITY);
  localparam logic [9:0] FRAME_CAP   = 10'(FRAME_CAPACITY);

  // configuration
  logic [7:0] start_marker, end_marker;
  logic [5:0] max_length;
  logic [4:0] stray_limit;

  // latched word
  logic [1:0]      op_q;
  logic [7:0]      byte_q;
  logic [TS_W-1:0] time_q;

  // parser state
  logic [FILL_W-1:0] frame_fill, frame_fill_next;
  logic [TS_W-1:0]   frame_time, frame_time_next;
  logic [7:0]        running_sum, running_sum_next;
  logic [7:0]        len_byte, len_byte_next;
  logic [7:0]        prev_byte, prev_byte_next;
  logic [SF_W-1:0]   stray_fill, stray_fill_next;
  logic [TS_W-1:0]   stray_time, stray_time_next;
  logic              pend, pend_next;

  // run being replayed
  kind_t           run_kind, run_kind_next;
  logic            run_stray, run_stray_next;
  logic [RUN_W-1:0] run_len, run_len_next;
  logic [TS_W-1:0] run_time, run_time_next;
  logic [7:0]      run_sum, run_sum_next;
  logic [RUN_W-1:0] rd_idx;

  logic       run_go, frame_we, stray_we_exec;
  logic [7:0] stray_lim, max_eff;
  logic [9:0] frame_total, fill_ext;
  logic [7:0] frame_q, stray_q;

  always_comb begin
    if (stray_limit == '0) begin
      stray_lim = 8'd1;
    end else if (8'(stray_limit) > STRAY_CAP) begin
      stray_lim = STRAY_CAP;
    end else begin
      stray_lim = 8'(stray_limit);
    end
    max_eff = (8'(max_length) > MAX_LEN_CAP) ? MAX_LEN_CAP : 8'(max_length);
  end

  assign frame_total = 10'(len_byte) + 10'(MIN_LENGTH);
  assign fill_ext    = 10'(frame_fill);

  always_comb begin
    frame_fill_next  = frame_fill;
    frame_time_next  = frame_time;
    running_sum_next = running_sum;
    len_byte_next    = len_byte;
    prev_byte_next   = prev_byte;
    stray_fill_next  = stray_fill;
    stray_time_next  = stray_time;
    pend_next        = 1'b0;
    run_go           = 1'b0;
    run_kind_next    = run_kind;
    run_stray_next   = run_stray;
    run_len_next     = run_len;
    run_time_next    = run_time;
    run_sum_next     = run_sum;
    frame_we         = 1'b0;
    stray_we_exec    = 1'b0;

    unique case (op_t'(op_q))
      OP_BYTE: begin
        prev_byte_next = byte_q;
        if (frame_fill == '0) begin
          if (byte_q != start_marker) begin
            if (8'(stray_fill) >= stray_lim) begin
              // hold full: flush it, the new byte goes in once the run is out
              run_go          = 1'b1;
              run_kind_next   = KIND_STRAY;
              run_stray_next  = 1'b1;
              run_len_next    = RUN_W'(stray_fill);
              run_time_next   = stray_time;
              run_sum_next    = '0;
              stray_fill_next = '0;
              pend_next       = 1'b1;
            end else begin
              stray_we_exec   = 1'b1;
              stray_fill_next = stray_fill + SF_W'(1);
              if (stray_fill == '0) stray_time_next = time_q;
            end
          end else begin
            if (stray_fill != '0) begin
              run_go         = 1'b1;
              run_kind_next  = KIND_STRAY;
              run_stray_next = 1'b1;
              run_len_next   = RUN_W'(stray_fill);
              run_time_next  = stray_time;
              run_sum_next   = '0;
            end
            stray_fill_next  = '0;
            frame_we         = 1'b1;
            frame_fill_next  = FILL_W'(1);
            frame_time_next  = time_q;
            running_sum_next = '0;
          end
        end else if (frame_fill == FILL_W'(1)) begin
          frame_we         = 1'b1;
          len_byte_next    = byte_q;
          running_sum_next = byte_q;
          frame_fill_next  = FILL_W'(2);
          if (byte_q < MIN_LENGTH || byte_q > max_eff) begin
            run_go          = 1'b1;
            run_kind_next   = (byte_q < MIN_LENGTH) ? KIND_LEN_SMALL : KIND_LEN_LARGE;
            run_stray_next  = 1'b0;
            run_len_next    = RUN_W'(2);
            run_time_next   = frame_time;
            run_sum_next    = '0;
            frame_fill_next = '0;
          end
        end else if (fill_ext >= FRAME_CAP) begin
          frame_fill_next = '0;
        end else begin
          frame_we        = 1'b1;
          frame_fill_next = frame_fill + FILL_W'(1);
          // payload bytes only, not checksum or end byte
          if (fill_ext + 10'd2 < frame_total) begin
            running_sum_next = running_sum + byte_q;
          end
          if (fill_ext + 10'd1 >= frame_total) begin
            run_go         = 1'b1;
            run_stray_next = 1'b0;
            if (byte_q != end_marker) begin
              run_kind_next = KIND_BAD_END;
            end else if (prev_byte != running_sum) begin
              run_kind_next = KIND_BAD_SUM;
            end else begin
              run_kind_next = KIND_OK;
            end
            run_len_next    = RUN_W'(frame_fill) + RUN_W'(1);
            run_time_next   = frame_time;
            run_sum_next    = running_sum;
            frame_fill_next = '0;
          end
        end
      end
      OP_TIMEOUT, OP_OVERFLOW: begin
        if (frame_fill != '0) begin
          run_go          = 1'b1;
          run_kind_next   = (op_t'(op_q) == OP_TIMEOUT) ? KIND_TIMEOUT : KIND_OVERFLOW;
          run_stray_next  = 1'b0;
          run_len_next    = RUN_W'(frame_fill);
          run_time_next   = frame_time;
          run_sum_next    = '0;
          frame_fill_next = '0;
        end else if (stray_fill != '0) begin
          run_go          = 1'b1;
          run_kind_next   = KIND_STRAY;
          run_stray_next  = 1'b1;
          run_len_next    = RUN_W'(stray_fill);
          run_time_next   = stray_time;
          run_sum_next    = '0;
          stray_fill_next = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= START_MARKER_RESET;
      end_marker   <= END_MARKER_RESET;
      max_length   <= MAX_LENGTH_RESET;
      stray_limit  <= STRAY_LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_START_MARKER: start_marker <= cfg_data;
        CFG_END_MARKER:   end_marker   <= cfg_data;
        CFG_MAX_LENGTH:   max_length   <= cfg_data[5:0];
        CFG_STRAY_LIMIT:  stray_limit  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_fill  <= '0;
      frame_time  <= '0;
      running_sum <= '0;
      stray_fill  <= '0;
      stray_time  <= '0;
      pend        <= 1'b0;
    end else if (cmd.exec) begin
      frame_fill  <= frame_fill_next;
      frame_time  <= frame_time_next;
      running_sum <= running_sum_next;
      stray_fill  <= stray_fill_next;
      stray_time  <= stray_time_next;
      pend        <= pend_next;
    end else if (cmd.finish && pend) begin
      stray_fill <= SF_W'(1);
      stray_time <= time_q;
      pend       <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q   <= item.operation;
      byte_q <= item.data_byte;
      time_q <= item.arrival_time[TS_W-1:0];
    end
    if (cmd.exec) begin
      len_byte  <= len_byte_next;
      prev_byte <= prev_byte_next;
      run_kind  <= run_kind_next;
      run_stray <= run_stray_next;
      run_len   <= run_len_next;
      run_time  <= run_time_next;
      run_sum   <= run_sum_next;
      rd_idx    <= '0;
    end else if (cmd.step) begin
      rd_idx <= rd_idx + RUN_W'(1);
    end
  end

  lcfs_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_CAPACITY),
    .AW    (FA_W)
  ) u_frame_ram (
    .clk   (clk),
    .we    (cmd.exec && frame_we),
    .waddr (frame_fill[FA_W-1:0]),
    .wdata (byte_q),
    .re    (cmd.rd_issue && !run_stray),
    .raddr (rd_idx[FA_W-1:0]),
    .rdata (frame_q)
  );

  lcfs_ram #(
    .WIDTH (8),
    .DEPTH (STRAY_CAPACITY),
    .AW    (SA_W)
  ) u_stray_ram (
    .clk   (clk),
    .we    ((cmd.exec && stray_we_exec) || (cmd.finish && pend)),
    .waddr ((cmd.finish && pend) ? '0 : stray_fill[SA_W-1:0]),
    .wdata (byte_q),
    .re    (cmd.rd_issue && run_stray),
    .raddr (rd_idx[SA_W-1:0]),
    .rdata (stray_q)
  );

  assign status.run_go   = run_go;
  assign status.run_last = ((rd_idx + RUN_W'(1)) == run_len);

  always_comb begin
    report.report_kind       = run_kind;
    report.report_byte       = run_stray ? stray_q : frame_q;
    report.byte_position     = 6'(rd_idx);
    report.last_in_report    = status.run_last;
    report.report_time       = TIME_W'(run_time);
    report.computed_checksum = run_sum;
  end

endmodule

FILE: hw/rtl/length_checksum_frame_sniffer.sv
// A word that causes no report goes from IDLE through EXEC and back to ready.
// A word that closes or abandons a run passes EXEC and READ before its first byte shows;
// every reported byte then takes a store read (READ), then the output word (SHOW), held until taken.
// One word at a time: no new word is taken until the word and its run are through.
// Synchronous reset clears the parser state and reloads the register defaults;
// the byte stores need no clearing since only entries written for a run are read.
// ----------------------------------------------------------------------------
// length_checksum_frame_sniffer
// Reassembles start/length/payload/checksum/end frames from received bytes and
// reports frames and stray bytes as tagged runs, one byte per output word.
// ----------------------------------------------------------------------------
module length_checksum_frame_sniffer import lcfs_pkg::*; #(
  parameter int FRAME_CAPACITY = 64,
  parameter int STRAY_CAPACITY = 16,
  parameter int TIME_BITS      = 48
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       item_valid,
  output logic       item_ready,
  input  item_t      item,
  output logic       report_valid,
  input  logic       report_ready,
  output report_t    report
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  // the user must change registers only between words; the block does not enforce it
  assign cfg_ready = 1'b1;

  lcfs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .report_valid (report_valid),
    .report_ready (report_ready),
    .status       (status),
    .cmd          (cmd)
  );

  lcfs_dpath #(
    .FRAME_CAPACITY (FRAME_CAPACITY),
    .STRAY_CAPACITY (STRAY_CAPACITY),
    .TIME_BITS      (TIME_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .status    (status),
    .report    (report)
  );

endmodule

FILE: hw/rtl/lcfs_checker.sv
// ----------------------------------------------------------------------------
// lcfs_checker
// Port-level checks of the frame sniffer, bound to the top level.
// ----------------------------------------------------------------------------
module lcfs_checker import lcfs_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_ready,
  input item_t   item,
  input logic    report_valid,
  input logic    report_ready,
  input report_t report
);

  // a stalled report word holds
  a_report_hold: assert property (@(posedge clk) disable iff (rst)
    report_valid && !report_ready |=> report_valid && $stable(report))
    else $error("report word changed while stalled");

  // no new word is taken while a run is being replayed
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(item_ready && report_valid))
    else $error("input ready during report run");

  // a taken word is worked on before the next one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("input ready right after a word was taken");

  // within a run the position steps by one and the time stays put
  a_run_steps: assert property (@(posedge clk) disable iff (rst)
    report_valid && report_ready && !report.last_in_report |-> ##2
      (report_valid &&
       report.byte_position == $past(report.byte_position, 2) + 6'd1 &&
       report.report_time == $past(report.report_time, 2)))
    else $error("report run broken");

endmodule

bind length_checksum_frame_sniffer lcfs_checker u_lcfs_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .item         (item),
  .report_valid (report_valid),
  .report_ready (report_ready),
  .report       (report)
);

FILE: test/lcfs_tb_pkg.sv
// ----------------------------------------------------------------------------
// lcfs_tb_pkg
// Scoreboard for the frame sniffer test: keeps its own copy of the parser
// state and registers, predicts the reported bytes of every accepted word and
// compares each output word with the oldest prediction.
// ----------------------------------------------------------------------------
package lcfs_tb_pkg;

  import lcfs_pkg::*;

  localparam int FRAME_DEPTH = 64;
  localparam int STRAY_DEPTH = 16;

  class sniffer_scoreboard;

    logic [7:0]        start_marker;
    logic [7:0]        end_marker;
    logic [5:0]        max_length;
    logic [4:0]        stray_limit;

    logic [7:0]        frame_bytes [FRAME_DEPTH];
    int                frame_fill;
    logic [TIME_W-1:0] frame_time;
    logic [7:0]        running_sum;
    logic [7:0]        held_bytes [STRAY_DEPTH];
    int                stray_fill;
    logic [TIME_W-1:0] stray_time;

    report_t           expected_reports [$];
    int                failures;

    function new();
      start_marker = START_MARKER_RESET;
      end_marker   = END_MARKER_RESET;
      max_length   = MAX_LENGTH_RESET;
      stray_limit  = STRAY_LIMIT_RESET;
      frame_fill   = 0;
      frame_time   = '0;
      running_sum  = '0;
      stray_fill   = 0;
      stray_time   = '0;
      failures     = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [7:0] value);
      case (idx)
        CFG_START_MARKER: start_marker = value;
        CFG_END_MARKER:   end_marker   = value;
        CFG_MAX_LENGTH:   max_length   = value[5:0];
        CFG_STRAY_LIMIT:  stray_limit  = value[4:0];
        default: ;
      endcase
    endfunction

    function int length_ceiling();
      return (int'(max_length) > FRAME_DEPTH - 2) ? FRAME_DEPTH - 2 : int'(max_length);
    endfunction

    function int hold_limit();
      int m;
      m = int'(stray_limit);
      if (m == 0) m = 1;
      if (m > STRAY_DEPTH) m = STRAY_DEPTH;
      return m;
    endfunction

    function void push_report(kind_t kind, logic [7:0] b, int pos, int n,
                              logic [TIME_W-1:0] t, logic [7:0] sum);
      report_t r;
      r.report_kind       = kind;
      r.report_byte       = b;
      r.byte_position     = pos[5:0];
      r.last_in_report    = (pos == n - 1);
      r.report_time       = t;
      r.computed_checksum = sum;
      expected_reports.push_back(r);
    endfunction

    function void queue_frame(kind_t kind, int n, logic [7:0] sum);
      for (int i = 0; i < n; i++) push_report(kind, frame_bytes[i], i, n, frame_time, sum);
    endfunction

    function void flush_strays();
      for (int i = 0; i < stray_fill; i++)
        push_report(KIND_STRAY, held_bytes[i], i, stray_fill, stray_time, 8'h00);
      stray_fill = 0;
    endfunction

    function void take_byte(logic [7:0] b, logic [TIME_W-1:0] t);
      int    idx;
      int    total;
      kind_t kind;
      if (frame_fill == 0) begin
        if (b != start_marker) begin
          if (stray_fill >= hold_limit()) flush_strays();
          if (stray_fill == 0) stray_time = t;
          if (stray_fill < STRAY_DEPTH) begin
            held_bytes[stray_fill] = b;
            stray_fill++;
          end
        end else begin
          flush_strays();
          frame_time     = t;
          frame_bytes[0] = b;
          frame_fill     = 1;
          running_sum    = '0;
        end
      end else if (frame_fill == 1) begin
        frame_bytes[1] = b;
        frame_fill     = 2;
        running_sum    = b;
        if (b < MIN_LENGTH) begin
          queue_frame(KIND_LEN_SMALL, 2, 8'h00);
          frame_fill = 0;
        end else if (int'(b) > length_ceiling()) begin
          queue_frame(KIND_LEN_LARGE, 2, 8'h00);
          frame_fill = 0;
        end
      end else begin
        idx   = frame_fill;
        total = 2 + int'(frame_bytes[1]);
        if (idx >= FRAME_DEPTH) begin
          frame_fill = 0;
        end else begin
          frame_bytes[idx] = b;
          frame_fill       = idx + 1;
          // checksum and end byte stay out of the sum
          if (idx + 2 < total) running_sum = running_sum + b;
          if (frame_fill >= total) begin
            if (frame_bytes[frame_fill-1] != end_marker) kind = KIND_BAD_END;
            else if (frame_bytes[frame_fill-2] != running_sum) kind = KIND_BAD_SUM;
            else kind = KIND_OK;
            queue_frame(kind, frame_fill, running_sum);
            frame_fill = 0;
          end
        end
      end
    endfunction

    function void note_word(item_t w);
      case (op_t'(w.operation))
        OP_BYTE: take_byte(w.data_byte, w.arrival_time);
        OP_TIMEOUT, OP_OVERFLOW: begin
          if (frame_fill > 0) begin
            if (op_t'(w.operation) == OP_TIMEOUT) queue_frame(KIND_TIMEOUT, frame_fill, 8'h00);
            else queue_frame(KIND_OVERFLOW, frame_fill, 8'h00);
            frame_fill = 0;
          end
          flush_strays();
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_report(report_t got);
      report_t want;
      if (expected_reports.size() == 0) begin
        $error("report with nothing expected: kind %0d byte %0h", got.report_kind,
               got.report_byte);
        failures++;
        return;
      end
      want = expected_reports.pop_front();
      compare_field("report_kind", TIME_W'(want.report_kind), TIME_W'(got.report_kind));
      compare_field("report_byte", TIME_W'(want.report_byte), TIME_W'(got.report_byte));
      compare_field("byte_position", TIME_W'(want.byte_position),
                    TIME_W'(got.byte_position));
      compare_field("last_in_report", TIME_W'(want.last_in_report),
                    TIME_W'(got.last_in_report));
      compare_field("report_time", want.report_time, got.report_time);
      compare_field("computed_checksum", TIME_W'(want.computed_checksum),
                    TIME_W'(got.computed_checksum));
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

  endclass

endpackage

FILE: test/length_checksum_frame_sniffer_tb.sv
// ----------------------------------------------------------------------------
// length_checksum_frame_sniffer_tb
// Drives the sniffer with directed frames and events, then random frames,
// noise and truncated frames under several register settings, with random
// idling on both sides and one long output hold-off; every reported byte is
// checked against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module length_checksum_frame_sniffer_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import lcfs_pkg::*;
  import lcfs_tb_pkg::*;

  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 600000;

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       cfg_valid    = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index    = CFG_START_MARKER;
  logic [7:0] cfg_data     = 8'h00;
  logic       item_valid   = 1'b0;
  logic       item_ready;
  item_t      item         = '0;
  logic       report_valid;
  logic       report_ready = 1'b0;
  report_t    report;

  sniffer_scoreboard board = new();

  bit         steady    = 1'b0;
  bit         long_hold = 1'b0;
  int         sent_count = 0;
  logic [7:0] start_now  = START_MARKER_RESET;
  logic [7:0] end_now    = END_MARKER_RESET;
  int         ceiling_now = int'(MAX_LENGTH_RESET);

  length_checksum_frame_sniffer DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .report_valid (report_valid),
    .report_ready (report_ready),
    .report       (report)
  );

  always #10 clk = ~clk;

  function automatic item_t word_at(op_t op, logic [7:0] b, logic [TIME_W-1:0] t);
    item_t w;
    w.operation    = op;
    w.data_byte    = b;
    w.arrival_time = t;
    return w;
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    logic [63:0] t;
    t = {$urandom(), $urandom()};
    return t[TIME_W-1:0];
  endfunction

  task automatic send_word(item_t w);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= w;
    do @(posedge clk); while (!item_ready);
    board.note_word(w);
    if (op_t'(w.operation) != OP_UNUSED) sent_count++;
  endtask

  task automatic send_op(op_t op, logic [7:0] b);
    send_word(word_at(op, b, rand_time()));
  endtask

  task automatic send_frame(int len, bit good_sum, bit good_end);
    logic [7:0] sum;
    logic [7:0] b;
    send_op(OP_BYTE, start_now);
    send_op(OP_BYTE, len[7:0]);
    sum = len[7:0];
    for (int i = 0; i < len - 2; i++) begin
      b   = 8'($urandom());
      sum = sum + b;
      send_op(OP_BYTE, b);
    end
    send_op(OP_BYTE, good_sum ? sum : sum + 8'($urandom_range(1, 255)));
    send_op(OP_BYTE, good_end ? end_now : end_now + 8'($urandom_range(1, 255)));
  endtask

  task automatic random_phase(int n);
    int target;
    int pick;
    int len;
    int short_cap;
    target    = sent_count + n;
    short_cap = (ceiling_now < 8) ? ceiling_now : 8;
    while (sent_count < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        len = ($urandom_range(0, 9) == 0) ? ceiling_now : $urandom_range(2, short_cap);
        send_frame(len, $urandom_range(0, 6) != 0, $urandom_range(0, 6) != 0);
      end else if (pick < 80) begin
        // noise run, long enough at times to fill the stray hold
        repeat ($urandom_range(1, 20)) send_op(OP_BYTE, 8'($urandom()));
      end else if (pick < 88) begin
        send_op(OP_BYTE, start_now);
        if ($urandom_range(0, 1)) send_op(OP_BYTE, 8'($urandom_range(0, 1)));
        else send_op(OP_BYTE, 8'($urandom_range(ceiling_now + 1, 255)));
      end else if (pick < 95) begin
        // frame cut short by an event
        send_op(OP_BYTE, start_now);
        if ($urandom_range(0, 3) != 0) begin
          len = $urandom_range(2, short_cap);
          send_op(OP_BYTE, len[7:0]);
          repeat ($urandom_range(0, len - 1)) send_op(OP_BYTE, 8'($urandom()));
        end
        send_op(op_t'($urandom_range(1, 2)), 8'($urandom()));
      end else begin
        send_op(op_t'($urandom_range(1, 3)), 8'($urandom()));
      end
    end
  endtask

  // wait until every expected byte is out and the last word has settled
  task automatic drain();
    item_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, value);
  endtask

  task automatic configure(logic [7:0] sm, logic [7:0] em, logic [5:0] ml, logic [4:0] sl);
    write_reg(CFG_START_MARKER, sm);
    write_reg(CFG_END_MARKER, em);
    write_reg(CFG_MAX_LENGTH, {2'b00, ml});
    write_reg(CFG_STRAY_LIMIT, {3'b000, sl});
    cfg_valid   <= 1'b0;
    start_now   = sm;
    end_now     = em;
    ceiling_now = (int'(ml) > FRAME_DEPTH - 2) ? FRAME_DEPTH - 2 : int'(ml);
  endtask

  initial begin : report_sink
    int stall;
    forever begin
      stall = steady ? 0 : $urandom_range(0, 6);
      if (long_hold) begin
        stall     = HOLD_CYCLES;
        long_hold = 1'b0;
      end
      if (stall > 0) begin
        report_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      report_ready <= 1'b1;
      do @(posedge clk); while (!report_valid);
      board.check_report(report);
    end
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // ignored word, then an event with nothing held
    send_word(word_at(OP_UNUSED, 8'hFF, '0));
    send_word(word_at(OP_TIMEOUT, 8'h00, {TIME_W{1'b1}}));
    // strays flushed by a frame start
    send_word(word_at(OP_BYTE, 8'h00, {TIME_W{1'b1}}));
    send_op(OP_BYTE, 8'hFF);
    send_word(word_at(OP_BYTE, start_now, '0));
    send_op(OP_BYTE, 8'h00);
    // length too large
    send_op(OP_BYTE, start_now);
    send_op(OP_BYTE, 8'hFF);
    // good frame with no payload
    send_op(OP_BYTE, start_now);
    send_op(OP_BYTE, MIN_LENGTH);
    send_op(OP_BYTE, MIN_LENGTH);
    send_op(OP_BYTE, end_now);
    // bad end wins over bad checksum
    send_op(OP_BYTE, start_now);
    send_op(OP_BYTE, 8'h03);
    send_op(OP_BYTE, 8'hAA);
    send_op(OP_BYTE, 8'h00);
    send_op(OP_BYTE, 8'h00);
    // bad checksum only
    send_op(OP_BYTE, start_now);
    send_op(OP_BYTE, MIN_LENGTH);
    send_op(OP_BYTE, 8'h55);
    send_op(OP_BYTE, end_now);
    // open frame abandoned by timeout, held stray by overflow
    send_op(OP_BYTE, start_now);
    send_op(OP_BYTE, 8'h05);
    send_op(OP_BYTE, 8'h11);
    send_op(OP_TIMEOUT, 8'h00);
    send_op(OP_BYTE, 8'h12);
    send_op(OP_OVERFLOW, 8'hFF);

    drain();
    configure(8'h00, 8'hFF, 6'd2, 5'd1);
    random_phase(15);

    drain();
    steady = 1'b1;
    configure(8'hFF, 8'h00, 6'd63, 5'd31);
    random_phase(15);

    drain();
    steady = 1'b0;
    configure(8'($urandom()), 8'($urandom()), 6'($urandom_range(2, 63)), 5'd0);
    random_phase(15);

    // back to defaults, with the output held off once a full frame's report has begun
    drain();
    long_hold = 1'b1;
    configure(START_MARKER_RESET, END_MARKER_RESET, MAX_LENGTH_RESET, STRAY_LIMIT_RESET);
    send_frame(ceiling_now, 1'b1, 1'b1);
    random_phase(10);

    drain();
    if (board.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/lcfs_pkg.sv
hw/rtl/lcfs_ram.sv
hw/rtl/lcfs_ctrl.sv
hw/rtl/lcfs_dpath.sv
hw/rtl/length_checksum_frame_sniffer.sv
hw/rtl/lcfs_checker.sv
test/lcfs_tb_pkg.sv
test/length_checksum_frame_sniffer_tb.sv
